FILE: sv/crt_pkg.sv
package crt_pkg;

    // Field widths of the words on the channels.
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 11;
    localparam int LEN_W    = 32;
    localparam int STATUS_W = 3;
    localparam int MISS_W   = 10;
    localparam int CNT_W    = 11;
    localparam int REJ_W    = 32;
    localparam int BYTES_W  = 48;

    // Default bitmap size in chunks.
    localparam int MAX_CHUNKS_DEF = 1024;

    // The bitmap is held as words of 32 flags.
    localparam int WORD_W  = 32;
    localparam int WORD_SH = 5;
    localparam int SCAN_W  = IDX_W - WORD_SH;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIGEST     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd4;

    // Position of the lowest set bit of a bitmap word.
    function automatic logic [WORD_SH-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [WORD_SH-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = WORD_SH'(i);
            end
        end
        return pos;
    endfunction

endpackage

FILE: sv/crt_ram.sv
module crt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port; read data holds when not enabled.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/chunk_receipt_tracker_core.sv
// Chunk receipt tracker.
// Input channel (s_valid/s_ready) takes one command word: record a chunk, find the
// next missing chunk from a start index, or clear the tracker. Every command gives
// exactly one result word on the output channel (m_valid/m_ready) carrying a status,
// the missing index of a find, the received, rejected and byte totals and a
// completion flag. The chunk count of the packet is written over the cfg channel,
// which is always ready; it should only be changed while the tracker is idle.
// The received flags live in a one-port-read, one-port-write RAM of 32-bit words.
// A record reads its RAM word on acceptance, then does the update and write-back;
// a range error reads nothing. A find reads one bitmap word per cycle. A clear
// sweeps the whole RAM before its result.
// After reset the same sweep zeroes the RAM: s_ready stays low until it ends. The
// result sits in an output register, so a new command is accepted while the
// previous result waits; when the receiver stalls, the tracker holds its next
// finished result and accepts nothing further until the output register is free.
module chunk_receipt_tracker_core #(
    parameter int MAX_CHUNKS = crt_pkg::MAX_CHUNKS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crt_pkg::IDX_W-1:0]        cfg_chunk_total,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [crt_pkg::CMD_W-1:0]        s_cmd,
    input  logic [crt_pkg::IDX_W-1:0]        s_chunk_index,
    input  logic [crt_pkg::LEN_W-1:0]        s_payload_len,
    input  logic                             s_digest_match,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [crt_pkg::STATUS_W-1:0]     m_status,
    output logic [crt_pkg::MISS_W-1:0]       m_missing_index,
    output logic [crt_pkg::CNT_W-1:0]        m_received_total,
    output logic [crt_pkg::REJ_W-1:0]        m_rejected_total,
    output logic [crt_pkg::BYTES_W-1:0]      m_byte_total,
    output logic                             m_complete
);

    import crt_pkg::*;

    localparam int WORDS  = (MAX_CHUNKS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    // Controller states.
    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_FIND  = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;

    // Operations finished in the execute state.
    localparam logic [1:0] OP_REC = 2'd0;
    localparam logic [1:0] OP_ERR = 2'd1;
    localparam logic [1:0] OP_CLR = 2'd2;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [SCAN_W-1:0]   scan_reg, scan_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                match_reg, match_next;
    logic [IDX_W-1:0]    total_reg;

    logic [CNT_W-1:0]    rcv_reg, rcv_next;
    logic [REJ_W-1:0]    rej_reg, rej_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [MISS_W-1:0]   m_missing_reg, m_missing_next;
    logic [CNT_W-1:0]    m_rcv_reg, m_rcv_next;
    logic [REJ_W-1:0]    m_rej_reg, m_rej_next;
    logic [BYTES_W-1:0]  m_bytes_reg, m_bytes_next;
    logic                m_complete_reg, m_complete_next;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_wdata, rd_data;

    logic                out_free;
    logic                total_ok;
    logic                load;
    logic [STATUS_W-1:0] res_status;
    logic [MISS_W-1:0]   res_missing;
    logic [SCAN_W-1:0]   start_word, total_word, last_word;
    logic [IDX_W-1:0]    total_m1;
    logic [WORD_W-1:0]   lo_mask, hi_mask, cand;
    logic [WORD_SH-1:0]  cand_pos;
    logic                bit_set;
    logic [BYTES_W:0]    bytes_sum;

    // Bitmap store.
    crt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (rd_data)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign total_ok  = (total_reg != '0) && (32'(total_reg) <= 32'(MAX_CHUNKS));

    // Search window within the word being scanned.
    assign start_word = idx_reg[IDX_W-1:WORD_SH];
    assign total_word = total_reg[IDX_W-1:WORD_SH];
    assign total_m1   = total_reg - IDX_W'(1);
    assign last_word  = total_m1[IDX_W-1:WORD_SH];
    assign lo_mask    = (scan_reg == start_word) ? ({WORD_W{1'b1}} << idx_reg[WORD_SH-1:0])
                                                 : {WORD_W{1'b1}};
    always_comb begin
        if (scan_reg < total_word) begin
            hi_mask = {WORD_W{1'b1}};
        end else if (scan_reg == total_word) begin
            hi_mask = (WORD_W'(1) << total_reg[WORD_SH-1:0]) - WORD_W'(1);
        end else begin
            hi_mask = '0;
        end
    end
    assign cand     = ~rd_data & lo_mask & hi_mask;
    assign cand_pos = lowest_set(cand);

    // Record update helpers.
    assign bit_set   = rd_data[idx_reg[WORD_SH-1:0]];
    assign bytes_sum = (BYTES_W+1)'(bytes_reg) + (BYTES_W+1)'(len_reg);

    // Command sequencing, RAM access and result assembly.
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        clr_addr_next = clr_addr_reg;
        scan_next     = scan_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        match_next    = match_reg;
        rcv_next      = rcv_reg;
        rej_next      = rej_reg;
        bytes_next    = bytes_reg;

        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_missing_next  = m_missing_reg;
        m_rcv_next      = m_rcv_reg;
        m_rej_next      = m_rej_reg;
        m_bytes_next    = m_bytes_reg;
        m_complete_next = m_complete_reg;

        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(idx_reg[IDX_W-1:WORD_SH]);
        ram_wdata = rd_data | (WORD_W'(1) << idx_reg[WORD_SH-1:0]);
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(scan_reg);

        load        = 1'b0;
        res_status  = ST_OK;
        res_missing = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg) inside
            S_INIT, S_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(WORDS - 1)) begin
                    clr_addr_next = '0;
                    if (state_reg == S_INIT) begin
                        state_next = S_IDLE;
                    end else begin
                        op_next    = OP_CLR;
                        state_next = S_EXEC;
                    end
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    idx_next   = s_chunk_index;
                    len_next   = s_payload_len;
                    match_next = s_digest_match;
                    scan_next  = s_chunk_index[IDX_W-1:WORD_SH];
                    ram_raddr  = ADDR_W'(s_chunk_index[IDX_W-1:WORD_SH]);
                    op_next    = OP_ERR;
                    state_next = S_EXEC;
                    unique case (s_cmd)
                        CMD_RECORD: begin
                            if (total_ok && (s_chunk_index < total_reg)) begin
                                op_next = OP_REC;
                                ram_re  = 1'b1;
                            end
                        end
                        CMD_FIND: begin
                            if (total_ok && (s_chunk_index <= total_reg)) begin
                                ram_re     = 1'b1;
                                state_next = S_FIND;
                            end
                        end
                        CMD_CLEAR: begin
                            rcv_next      = '0;
                            rej_next      = '0;
                            bytes_next    = '0;
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        default: begin
                            op_next = OP_ERR;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    unique case (op_reg)
                        OP_REC: begin
                            if (!match_reg) begin
                                res_status = ST_DIGEST;
                                if (rej_reg != '1) begin
                                    rej_next = rej_reg + REJ_W'(1);
                                end
                            end else if (bit_set) begin
                                res_status = ST_DUP;
                            end else begin
                                ram_we = 1'b1;
                                if (rcv_reg != '1) begin
                                    rcv_next = rcv_reg + CNT_W'(1);
                                end
                                bytes_next = bytes_sum[BYTES_W] ? {BYTES_W{1'b1}}
                                                                : bytes_sum[BYTES_W-1:0];
                            end
                        end
                        OP_CLR: begin
                            res_status = ST_OK;
                        end
                        default: begin
                            res_status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (cand != '0) begin
                    if (out_free) begin
                        load        = 1'b1;
                        res_status  = ST_OK;
                        res_missing = MISS_W'({scan_reg, cand_pos});
                        state_next  = S_IDLE;
                    end
                end else if (scan_reg >= last_word) begin
                    if (out_free) begin
                        load       = 1'b1;
                        res_status = ST_INCOMPLETE;
                        state_next = S_IDLE;
                    end
                end else begin
                    scan_next = scan_reg + SCAN_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(scan_reg + SCAN_W'(1));
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Capture the finished result word.
        if (load) begin
            m_valid_next    = 1'b1;
            m_status_next   = res_status;
            m_missing_next  = res_missing;
            m_rcv_next      = rcv_next;
            m_rej_next      = rej_next;
            m_bytes_next    = bytes_next;
            m_complete_next = total_ok && (rcv_next == total_reg);
        end
    end

    // Control state and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            op_reg       <= OP_ERR;
            clr_addr_reg <= '0;
            total_reg    <= '0;
            rcv_reg      <= '0;
            rej_reg      <= '0;
            bytes_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            clr_addr_reg <= clr_addr_next;
            rcv_reg      <= rcv_next;
            rej_reg      <= rej_next;
            bytes_reg    <= bytes_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid) begin
                total_reg <= cfg_chunk_total;
            end
        end
    end

    // Command and result payload.
    always_ff @(posedge aclk) begin
        scan_reg       <= scan_next;
        idx_reg        <= idx_next;
        len_reg        <= len_next;
        match_reg      <= match_next;
        m_status_reg   <= m_status_next;
        m_missing_reg  <= m_missing_next;
        m_rcv_reg      <= m_rcv_next;
        m_rej_reg      <= m_rej_next;
        m_bytes_reg    <= m_bytes_next;
        m_complete_reg <= m_complete_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_missing_index  = m_missing_reg;
    assign m_received_total = m_rcv_reg;
    assign m_rejected_total = m_rej_reg;
    assign m_byte_total     = m_bytes_reg;
    assign m_complete       = m_complete_reg;

endmodule
